/* design/tcw_pkg.sv */
// tcw_pkg: shared constants, codes and control types of the text console writer
// no dependencies; imported by the interfaces and every module of the block
package tcw_pkg;

  localparam int ACTION_W    = 2;
  localparam int CHAR_W      = 8;
  localparam int ATTR_W      = 8;
  localparam int IDX_W       = 11;
  localparam int POS_W       = 11;
  localparam int CELL_W      = ATTR_W + CHAR_W;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'd32;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd15;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT       = 2'd0,
    ACT_BACKSPACE = 2'd1,
    ACT_CLEAR     = 2'd2,
    ACT_READ      = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCROLL,
    ST_BLANK_ROW,
    ST_CLEAR,
    ST_WRITE_CHAR,
    ST_WRITE_BLANK,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_WR_CHAR,
    MEM_WR_BLANK_CUR,
    MEM_WR_BLANK_CNT,
    MEM_SCROLL,
    MEM_READ
  } mem_op_t;

  typedef struct packed {
    logic    capture;
    logic    cur_newline;
    logic    cur_back;
    logic    cur_home;
    logic    cur_advance;
    logic    cnt_clear;
    logic    cnt_inc;
    mem_op_t mem_op;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    action_t act;
    logic    is_newline;
    logic    col_full;
    logic    at_bottom;
    logic    at_origin;
    logic    read_hit;
    logic    scroll_end;
    logic    sweep_end;
  } status_t;

endpackage

/* design/tcw_in_if.sv */
// tcw_in_if: request channel of the text console writer (valid/ready + payload)
// depends on tcw_pkg for field widths
interface tcw_in_if import tcw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [CHAR_W-1:0]   char_code;
  logic [IDX_W-1:0]    cell_index;

  modport source (output valid, output action, output char_code, output cell_index,
                  input ready);
  modport sink   (input valid, input action, input char_code, input cell_index,
                  output ready);
endinterface

/* design/tcw_out_if.sv */
// tcw_out_if: result channel of the text console writer (valid/ready + payload)
// depends on tcw_pkg for field widths
interface tcw_out_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  cursor_pos;
  logic [CHAR_W-1:0] read_char;
  logic [ATTR_W-1:0] read_attr;

  modport source (output valid, output cursor_pos, output read_char, output read_attr,
                  input ready);
  modport sink   (input valid, input cursor_pos, input read_char, input read_attr,
                  output ready);
endinterface

/* design/tcw_ctrl.sv */
// tcw_ctrl: state machine sequencing puts, backspaces, scrolls, sweeps, reads and result handoff
// depends on tcw_pkg; drives tcw_dp through cmd_t and watches status_t
module tcw_ctrl import tcw_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (sts.act)
          ACT_PUT: begin
            if (sts.is_newline || sts.col_full) begin
              if (sts.at_bottom)       state_nxt = ST_SCROLL;
              else if (sts.is_newline) state_nxt = ST_DONE;
              else                     state_nxt = ST_WRITE_CHAR;
            end else begin
              state_nxt = ST_WRITE_CHAR;
            end
          end
          ACT_BACKSPACE: state_nxt = sts.at_origin ? ST_DONE : ST_WRITE_BLANK;
          ACT_CLEAR:     state_nxt = ST_CLEAR;
          ACT_READ:      state_nxt = ST_DONE;
          default:       state_nxt = ST_DONE;
        endcase
      end
      ST_SCROLL: begin
        if (sts.scroll_end) state_nxt = ST_BLANK_ROW;
      end
      ST_BLANK_ROW: begin
        if (sts.sweep_end) state_nxt = sts.is_newline ? ST_DONE : ST_WRITE_CHAR;
      end
      ST_CLEAR: begin
        if (sts.sweep_end) state_nxt = ST_DONE;
      end
      ST_WRITE_CHAR:  state_nxt = ST_DONE;
      ST_WRITE_BLANK: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_DECODE: begin
        unique case (sts.act)
          ACT_PUT: begin
            if (sts.is_newline || sts.col_full) begin
              cmd.cur_newline = 1'b1;
              cmd.cnt_clear   = 1'b1;
            end
          end
          ACT_BACKSPACE: cmd.cur_back = !sts.at_origin;
          ACT_CLEAR:     cmd.cnt_clear = 1'b1;
          ACT_READ:      cmd.mem_op = MEM_READ;
          default:       cmd.mem_op = MEM_NONE;
        endcase
      end
      ST_SCROLL: begin
        cmd.mem_op  = MEM_SCROLL;
        // last step only drains the pending write; the counter then starts the blank row
        cmd.cnt_inc = !sts.scroll_end;
      end
      ST_BLANK_ROW: begin
        cmd.mem_op  = MEM_WR_BLANK_CNT;
        cmd.cnt_inc = 1'b1;
      end
      ST_CLEAR: begin
        cmd.mem_op   = MEM_WR_BLANK_CNT;
        cmd.cnt_inc  = 1'b1;
        cmd.cur_home = sts.sweep_end;
      end
      ST_WRITE_CHAR: begin
        cmd.mem_op      = MEM_WR_CHAR;
        cmd.cur_advance = 1'b1;
      end
      ST_WRITE_BLANK: cmd.mem_op = MEM_WR_BLANK_CUR;
      ST_DONE:        cmd.out_load = !out_valid_r || out_ready;
      default:        cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  assign out_valid = out_valid_r;

endmodule

/* design/tcw_dp.sv */
// tcw_dp: cursor registers, sweep counter, cell store and result register
// depends on tcw_pkg; commanded by tcw_ctrl
module tcw_dp import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [CHAR_W-1:0]   in_char_code,
  input  logic [IDX_W-1:0]    in_cell_index,
  input  logic                cfg_we,
  input  logic [ATTR_W-1:0]   cfg_wdata,
  input  cmd_t                cmd,
  output status_t             sts,
  output logic [POS_W-1:0]    out_cursor_pos,
  output logic [CHAR_W-1:0]   out_read_char,
  output logic [ATTR_W-1:0]   out_read_attr
);

  localparam int CELLS       = ROWS * COLUMNS;
  localparam int SHIFT_CELLS = CELLS - COLUMNS;
  localparam int AW          = $clog2(CELLS);
  localparam int PW          = $clog2(CELLS + 1);
  localparam int RW          = $clog2(ROWS);
  localparam int CW          = $clog2(COLUMNS + 1);

  action_t           act_r;
  logic [CHAR_W-1:0] char_r;
  logic [IDX_W-1:0]  idx_r;
  logic [ATTR_W-1:0] attr_r;

  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [PW-1:0] base_r, base_nxt;
  logic [PW-1:0] cnt_r, cnt_nxt;

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rd_data_r;

  logic [POS_W-1:0]  pos_r;
  logic [CHAR_W-1:0] rchar_r;
  logic [ATTR_W-1:0] rattr_r;

  logic [PW-1:0]     cur_addr;
  logic [PW-1:0]     src_addr;
  logic [PW-1:0]     dst_addr;
  logic [31:0]       pos_ext;
  logic [31:0]       idx_ext;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_wa, mem_ra;
  logic [CELL_W-1:0] mem_wd;

  // request capture and attribute register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r  <= action_t'(in_action);
      char_r <= in_char_code;
      idx_r  <= in_cell_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)      attr_r <= ATTR_RESET;
    else if (cfg_we) attr_r <= cfg_wdata;
  end

  // cursor: base_r tracks row*COLUMNS so no multiply is needed
  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    base_nxt = base_r;
    if (cmd.cur_home) begin
      row_nxt  = '0;
      col_nxt  = '0;
      base_nxt = '0;
    end else if (cmd.cur_newline) begin
      col_nxt = '0;
      if (!sts.at_bottom) begin
        row_nxt  = row_r + RW'(1);
        base_nxt = base_r + PW'(COLUMNS);
      end
    end else if (cmd.cur_back) begin
      if (col_r == '0) begin
        row_nxt  = row_r - RW'(1);
        base_nxt = base_r - PW'(COLUMNS);
        col_nxt  = CW'(COLUMNS - 1);
      end else begin
        col_nxt = col_r - CW'(1);
      end
    end else if (cmd.cur_advance) begin
      col_nxt = col_r + CW'(1);
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clear)    cnt_nxt = '0;
    else if (cmd.cnt_inc) cnt_nxt = cnt_r + PW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      base_r <= '0;
      cnt_r  <= '0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      base_r <= base_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign cur_addr = base_r + PW'(col_r);
  assign src_addr = cnt_r + PW'(COLUMNS);
  assign dst_addr = cnt_r - PW'(1);
  assign idx_ext  = 32'(idx_r);
  assign pos_ext  = 32'(cur_addr);

  // status back to the controller
  always_comb begin
    sts.act        = act_r;
    sts.is_newline = (char_r == NEWLINE_CHAR);
    sts.col_full   = (col_r == CW'(COLUMNS));
    sts.at_bottom  = (row_r == RW'(ROWS - 1));
    sts.at_origin  = (row_r == '0) && (col_r == '0);
    sts.read_hit   = (idx_ext < 32'(CELLS));
    sts.scroll_end = (cnt_r == PW'(SHIFT_CELLS));
    sts.sweep_end  = (cnt_r == PW'(CELLS - 1));
  end

  // cell store port selection
  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_wa = cur_addr[AW-1:0];
    mem_ra = idx_ext[AW-1:0];
    mem_wd = {attr_r, BLANK_CHAR};
    unique case (cmd.mem_op)
      MEM_WR_CHAR: begin
        mem_we = 1'b1;
        mem_wd = {attr_r, char_r};
      end
      MEM_WR_BLANK_CUR: mem_we = 1'b1;
      MEM_WR_BLANK_CNT: begin
        mem_we = 1'b1;
        mem_wa = cnt_r[AW-1:0];
      end
      MEM_SCROLL: begin
        // read one row ahead, write back the cell read in the previous cycle
        mem_re = (cnt_r < PW'(SHIFT_CELLS));
        mem_ra = src_addr[AW-1:0];
        mem_we = (cnt_r != '0);
        mem_wa = dst_addr[AW-1:0];
        mem_wd = rd_data_r;
      end
      MEM_READ: mem_re = sts.read_hit;
      default: begin
        mem_we = 1'b0;
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_data_r <= mem[mem_ra];
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pos_r <= pos_ext[POS_W-1:0];
      if (act_r == ACT_READ && sts.read_hit) begin
        rchar_r <= rd_data_r[CHAR_W-1:0];
        rattr_r <= rd_data_r[CELL_W-1:CHAR_W];
      end else begin
        rchar_r <= '0;
        rattr_r <= '0;
      end
    end
  end

  assign out_cursor_pos = pos_r;
  assign out_read_char  = rchar_r;
  assign out_read_attr  = rattr_r;

endmodule

/* design/text_console_writer.sv */
// text_console_writer: top level joining tcw_ctrl and tcw_dp to the channel interfaces
// depends on tcw_pkg, tcw_in_if, tcw_out_if, tcw_ctrl, tcw_dp
//
//   port     direction  carries
//   in_if    sink       request: action, char_code, cell_index
//   out_if   source     result: cursor_pos, read_char, read_attr
//   cfg_*    input      text_attribute write (cfg_we, cfg_wdata)
//
// one request at a time; a put or backspace passes through decode, one cell write and
// done, a read, a newline or a backspace at the origin through decode and done only.
// a bottom-row newline scrolls: copy up, then blank the last row; a bottom-row wrap also
// writes its character after. clear sweeps every cell, one per cycle, and homes the cursor.
// the result register lets a new request in while a result is still waiting;
// a stalled result holds the block in its last step. reset leaves the cells unwritten.
module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic              clk,
  input  logic              rst_n,
  tcw_in_if.sink            in_if,
  tcw_out_if.source         out_if,
  input  logic              cfg_we,
  input  logic [ATTR_W-1:0] cfg_wdata
);

  cmd_t    cmd;
  status_t sts;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_action      (in_if.action),
    .in_char_code   (in_if.char_code),
    .in_cell_index  (in_if.cell_index),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .cmd            (cmd),
    .sts            (sts),
    .out_cursor_pos (out_if.cursor_pos),
    .out_read_char  (out_if.read_char),
    .out_read_attr  (out_if.read_attr)
  );

  // one request in flight: no acceptance in the cycle after one
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("request accepted while previous one in progress");

  // a waiting result is never overwritten
  assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.out_load && out_if.valid && !out_if.ready))
    else $error("result register overwritten before handoff");

  // reported cursor never passes the end of the screen
  assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (32'(out_if.cursor_pos) <= 32'(ROWS * COLUMNS)))
    else $error("cursor position beyond screen");

  // a request is only taken with the controller ready to capture it
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |-> cmd.capture)
    else $error("request accepted without capture");

endmodule

/* verif/text_console_writer_tb.sv */
// text_console_writer_tb: self-checking bench for the text console writer
// drives puts, backspaces, clears and cell reads and checks every result against scripted values or a screen model
// depends on tcw_pkg, tcw_in_if, tcw_out_if and text_console_writer
module text_console_writer_tb import tcw_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCR_COLS   = DEF_COLUMNS;
  localparam int SCR_ROWS   = DEF_ROWS;
  localparam int SCR_CELLS  = SCR_ROWS * SCR_COLS;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_LEN   = 400;
  localparam int PHASE_LEN  = 410;
  localparam int SCRIPT_LEN = 24;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [CHAR_W-1:0] ch;
    logic [ATTR_W-1:0] attr;
  } console_result_t;

  typedef struct packed {
    action_t           act;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
  } console_req_t;

  typedef struct packed {
    action_t           act;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
    logic [7:0]        reps;
    console_result_t   want;
  } script_row_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [ATTR_W-1:0] cfg_wdata;

  tcw_in_if  request_ch ();
  tcw_out_if result_ch ();

  text_console_writer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (request_ch),
    .out_if    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // screen model state
  logic [CELL_W-1:0] screen_mem [SCR_CELLS];
  int unsigned       cur_row;
  int unsigned       cur_col;
  logic [ATTR_W-1:0] text_attr;

  console_result_t awaited_results [$];
  int              error_count;
  int              sent_count;
  int              burst_left;
  bit              gap_free;
  bit              long_hold_pending;
  int              idle_cycles;

  // only the last repetition of a row carries the typed result
  script_row_t directed_script [SCRIPT_LEN] = '{
    '{ACT_READ,      8'h00,        11'd2047, 8'd1,  '{11'd0,    8'd0,       8'd0}},
    '{ACT_BACKSPACE, 8'h00,        11'd0,    8'd1,  '{11'd0,    8'd0,       8'd0}},
    '{ACT_CLEAR,     8'h00,        11'd0,    8'd1,  '{11'd0,    8'd0,       8'd0}},
    '{ACT_READ,      8'h00,        11'd0,    8'd1,  '{11'd0,    BLANK_CHAR, ATTR_RESET}},
    '{ACT_READ,      8'h00,        11'd1999, 8'd1,  '{11'd0,    BLANK_CHAR, ATTR_RESET}},
    '{ACT_READ,      8'h00,        11'd2000, 8'd1,  '{11'd0,    8'd0,       8'd0}},
    '{ACT_PUT,       8'h00,        11'd0,    8'd1,  '{11'd1,    8'd0,       8'd0}},
    '{ACT_PUT,       8'hFF,        11'd2047, 8'd1,  '{11'd2,    8'd0,       8'd0}},
    '{ACT_READ,      8'hFF,        11'd1,    8'd1,  '{11'd2,    8'hFF,      ATTR_RESET}},
    '{ACT_BACKSPACE, 8'h00,        11'd0,    8'd1,  '{11'd1,    8'd0,       8'd0}},
    '{ACT_PUT,       NEWLINE_CHAR, 11'd0,    8'd1,  '{11'd80,   8'd0,       8'd0}},
    '{ACT_BACKSPACE, 8'h00,        11'd0,    8'd1,  '{11'd79,   8'd0,       8'd0}},
    '{ACT_PUT,       8'h61,        11'd0,    8'd1,  '{11'd80,   8'd0,       8'd0}},
    '{ACT_BACKSPACE, 8'h00,        11'd0,    8'd1,  '{11'd79,   8'd0,       8'd0}},
    '{ACT_PUT,       8'h62,        11'd0,    8'd1,  '{11'd80,   8'd0,       8'd0}},
    '{ACT_PUT,       8'h63,        11'd0,    8'd1,  '{11'd81,   8'd0,       8'd0}},
    '{ACT_READ,      8'h00,        11'd80,   8'd1,  '{11'd81,   8'h63,      ATTR_RESET}},
    '{ACT_PUT,       NEWLINE_CHAR, 11'd0,    8'd23, '{11'd1920, 8'd0,       8'd0}},
    '{ACT_PUT,       8'h7A,        11'd0,    8'd80, '{11'd2000, 8'd0,       8'd0}},
    '{ACT_PUT,       8'h71,        11'd0,    8'd1,  '{11'd1921, 8'd0,       8'd0}},
    '{ACT_READ,      8'h00,        11'd1840, 8'd1,  '{11'd1921, 8'h7A,      ATTR_RESET}},
    '{ACT_PUT,       NEWLINE_CHAR, 11'd0,    8'd1,  '{11'd1920, 8'd0,       8'd0}},
    '{ACT_READ,      8'h00,        11'd1999, 8'd1,  '{11'd1920, BLANK_CHAR, ATTR_RESET}},
    '{ACT_CLEAR,     8'h00,        11'd0,    8'd1,  '{11'd0,    8'd0,       8'd0}}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void blank_line(input int unsigned r);
    int unsigned c;
    for (c = 0; c < SCR_COLS; c++) screen_mem[r * SCR_COLS + c] = {text_attr, BLANK_CHAR};
  endfunction

  function automatic void next_line();
    int unsigned i;
    cur_col = 0;
    if (cur_row < SCR_ROWS - 1) begin
      cur_row++;
    end else begin
      for (i = 0; i < SCR_CELLS - SCR_COLS; i++) screen_mem[i] = screen_mem[i + SCR_COLS];
      blank_line(SCR_ROWS - 1);
    end
  endfunction

  function automatic console_result_t apply_console_action(input console_req_t rq);
    console_result_t res;
    int unsigned     r;
    res = '0;
    case (rq.act)
      ACT_PUT: begin
        if (rq.ch == NEWLINE_CHAR) begin
          next_line();
        end else begin
          // a full line only wraps once the next character shows up
          if (cur_col >= SCR_COLS) next_line();
          screen_mem[cur_row * SCR_COLS + cur_col] = {text_attr, rq.ch};
          cur_col++;
        end
      end
      ACT_BACKSPACE: begin
        if (cur_row != 0 || cur_col != 0) begin
          if (cur_col == 0) begin
            cur_row--;
            cur_col = SCR_COLS - 1;
          end else begin
            cur_col--;
          end
          screen_mem[cur_row * SCR_COLS + cur_col] = {text_attr, BLANK_CHAR};
        end
      end
      ACT_CLEAR: begin
        for (r = 0; r < SCR_ROWS; r++) blank_line(r);
        cur_row = 0;
        cur_col = 0;
      end
      default: begin
        if (rq.idx < SCR_CELLS) begin
          res.ch   = screen_mem[rq.idx][CHAR_W-1:0];
          res.attr = screen_mem[rq.idx][CELL_W-1:CHAR_W];
        end
      end
    endcase
    res.pos = POS_W'(cur_row * SCR_COLS + cur_col);
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  task automatic send_request(input console_req_t rq, input bit typed,
                              input console_result_t want);
    console_result_t predicted;
    request_ch.valid      <= 1'b1;
    request_ch.action     <= rq.act;
    request_ch.char_code  <= rq.ch;
    request_ch.cell_index <= rq.idx;
    do @(posedge clk); while (request_ch.ready !== 1'b1);
    predicted = apply_console_action(rq);
    awaited_results.push_back(typed ? want : predicted);
    sent_count++;
    if (!gap_free) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        request_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 25)) @(posedge clk);
        burst_left = $urandom_range(0, 30);
      end
    end
  endtask

  task automatic send_random(input action_t act, input int ch, input int idx);
    console_req_t rq;
    rq.act = act;
    rq.ch  = CHAR_W'(ch);
    rq.idx = IDX_W'(idx);
    send_request(rq, 1'b0, '0);
  endtask

  task automatic wait_for_drain(input int tail);
    request_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_text_attr(input logic [ATTR_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    text_attr = value;
  endtask

  task automatic run_random_phase(input int n_items);
    int stop_at, kind, len, k, p, idx;
    stop_at = sent_count + n_items;
    while (sent_count < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        // mostly short words, now and then 70 to 90 characters to force wraps
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(70, 90) : $urandom_range(1, 12);
        for (k = 0; k < len; k++)
          send_random(ACT_PUT, $urandom_range(0, 255), $urandom_range(0, 2047));
      end else if (kind < 60) begin
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++)
          send_random(ACT_PUT, int'(NEWLINE_CHAR), $urandom_range(0, 2047));
      end else if (kind < 74) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 100) : $urandom_range(1, 4);
        for (k = 0; k < len; k++)
          send_random(ACT_BACKSPACE, $urandom_range(0, 255), $urandom_range(0, 2047));
      end else if (kind < 98) begin
        k = $urandom_range(0, 19);
        p = int'(cur_row * SCR_COLS + cur_col);
        if (k < 13) begin
          idx = p - $urandom_range(0, 120);
          if (idx < 0) idx = 0;
        end else if (k < 18) begin
          idx = $urandom_range(0, SCR_CELLS - 1);
        end else begin
          idx = $urandom_range(SCR_CELLS, 2047);
        end
        send_random(ACT_READ, $urandom_range(0, 255), idx);
      end else begin
        send_random(ACT_CLEAR, $urandom_range(0, 255), $urandom_range(0, 2047));
      end
    end
  endtask

  // result side: stalls in segments of its own, plus one long hold-off on request
  initial begin
    int hold_left, seg_left, mode, tick;
    hold_left = 0;
    seg_left  = 0;
    mode      = 0;
    tick      = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 3);
          seg_left = $urandom_range(20, 300);
        end
        seg_left--;
        case (mode)
          0:       result_ch.ready <= 1'b1;
          1:       result_ch.ready <= 1'($urandom_range(0, 1));
          2:       result_ch.ready <= ($urandom_range(0, 7) == 0);
          default: result_ch.ready <= ((tick % 6) < 4);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    console_result_t want;
    if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (awaited_results.size() == 0) begin
        $error("result with no request outstanding, cursor_pos %0d", result_ch.cursor_pos);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("cursor_pos", 16'(want.pos), 16'(result_ch.cursor_pos));
        check_field("read_char", 16'(want.ch), 16'(result_ch.read_char));
        check_field("read_attr", 16'(want.attr), 16'(result_ch.read_attr));
      end
    end
  end

  always @(posedge clk) begin
    if ((request_ch.valid === 1'b1 && request_ch.ready === 1'b1) ||
        (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("text_console_writer_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    int            row, k, phase;
    logic [7:0]    attr_plan [4];
    console_req_t  rq;
    error_count       = 0;
    sent_count        = 0;
    burst_left        = 0;
    gap_free          = 1'b0;
    long_hold_pending = 1'b0;
    idle_cycles       = 0;
    cur_row           = 0;
    cur_col           = 0;
    text_attr         = ATTR_RESET;
    request_ch.valid      <= 1'b0;
    request_ch.action     <= ACT_PUT;
    request_ch.char_code  <= '0;
    request_ch.cell_index <= '0;
    cfg_we                <= 1'b0;
    cfg_wdata             <= '0;
    rst_n                 <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // nothing may read a cell before the clear in the third row
    for (row = 0; row < SCRIPT_LEN; row++) begin
      rq.act = directed_script[row].act;
      rq.ch  = directed_script[row].ch;
      rq.idx = directed_script[row].idx;
      for (k = 0; k < directed_script[row].reps; k++)
        send_request(rq, k == directed_script[row].reps - 1, directed_script[row].want);
    end
    wait_for_drain(8);

    attr_plan[0] = 8'h00;
    attr_plan[1] = 8'hFF;
    attr_plan[2] = 8'($urandom_range(0, 255));
    attr_plan[3] = 8'($urandom_range(0, 255));
    for (phase = 0; phase < 4; phase++) begin
      write_text_attr(attr_plan[phase]);
      // first phase: the sender never idles while the result side holds off
      gap_free = (phase == 0);
      if (phase == 0) long_hold_pending = 1'b1;
      run_random_phase(PHASE_LEN);
      wait_for_drain(8);
    end
    wait_for_drain(40);

    if (error_count == 0) begin
      $display("text_console_writer_tb: clean");
    end else begin
      $display("text_console_writer_tb: errors");
    end
    $finish;
  end

endmodule
